// ----- hdl/hu2d_pkg.sv -----
// Shared definitions for the HU to density and material converter.
// Field widths, register codes, item kinds and the section memory entry.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package hu2d_pkg;

  // Default sizes of the stores.
  localparam int DENSITY_EDGES_DEF    = 16;
  localparam int MATERIAL_EDGES_DEF   = 32;
  localparam int CORRECTION_DEPTH_DEF = 4096;

  // Field widths of the transfer items.
  localparam int KIND_W  = 2;
  localparam int HU_W    = 16;
  localparam int SLOT_W  = 12;
  localparam int OFS_W   = 32;
  localparam int SLOPE_W = 32;
  localparam int BIAS_W  = 16;
  localparam int CORR_W  = 18;
  localparam int DENS_W  = 32;
  localparam int DSEC_W  = 4;
  localparam int MSEC_W  = 5;

  // Configuration registers.
  localparam int DSU_W      = 4;
  localparam int MSU_W      = 5;
  localparam int ENTRIES_W  = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DSU_RESET     = 7;
  localparam int MSU_RESET     = 25;
  localparam int BASE_RESET    = -1000;
  localparam int ENTRIES_RESET = 0;

  // One millionth g/cm3 on the Q8.24 grid, rounded up.
  localparam int DENSITY_FLOOR = 17;

  typedef enum logic [KIND_W-1:0] {
    KIND_CONVERT,
    KIND_DENSITY,
    KIND_CORRECTION,
    KIND_MATERIAL
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DENSITY_SECTIONS,
    CFG_MATERIAL_SECTIONS,
    CFG_CORRECTION_BASE,
    CFG_CORRECTION_ENTRIES
  } cfg_reg_t;

  // One row of the section memory: a density section and a material edge.
  typedef struct packed {
    logic signed [HU_W-1:0]    dedge;
    logic        [OFS_W-1:0]   ofs;
    logic signed [SLOPE_W-1:0] slope;
    logic signed [BIAS_W-1:0]  bias;
    logic signed [HU_W-1:0]    medge;
  } sec_entry_t;

  // Control handed to the density arithmetic.
  typedef struct packed {
    logic start;
    logic corr_en;
  } calc_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/hu2d_calc.sv -----
// Density arithmetic: linear section term, correction multiply, floor and saturation.
// Four register stages started by one pulse; depends on hu2d_pkg.
`default_nettype none

module hu2d_calc (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire hu2d_pkg::calc_ctl_t                 ctl,
  input  wire logic        [hu2d_pkg::OFS_W-1:0]   ofs_i,
  input  wire logic signed [hu2d_pkg::SLOPE_W-1:0] slope_i,
  input  wire logic signed [hu2d_pkg::BIAS_W-1:0]  bias_i,
  input  wire logic signed [hu2d_pkg::HU_W-1:0]    value_i,
  input  wire logic        [hu2d_pkg::CORR_W-1:0]  corr_i,
  output logic                                     done_o,
  output logic             [hu2d_pkg::DENS_W-1:0]  density_o
);
  import hu2d_pkg::*;

  localparam int BSUM_W  = HU_W + 1;
  localparam int PROD1_W = SLOPE_W + BSUM_W;
  localparam int SUM_W   = PROD1_W + 2;
  localparam int LIN_W   = SUM_W - 8;
  localparam int LO_W    = 24;
  localparam int HI_W    = LIN_W - LO_W;
  localparam int PL_W    = LO_W + CORR_W;
  localparam int PH_W    = HI_W + CORR_W + 1;
  localparam int WIDE_W  = LIN_W + CORR_W + 1;
  localparam int SCL_W   = WIDE_W - 16;
  localparam int RND_LIN = 128;
  localparam int RND_COR = 32768;

  logic                       v1_r, v2_r, v3_r, done_r;
  logic signed [PROD1_W-1:0]  prod1_r;
  logic        [OFS_W-1:0]    ofs_r;
  logic        [CORR_W-1:0]   corr_r;
  logic                       corr_en_r;
  logic signed [LIN_W-1:0]    lin_r;
  logic        [PL_W-1:0]     pl_r;
  logic signed [PH_W-1:0]     ph_r;
  logic        [DENS_W-1:0]   density_r;

  logic signed [BSUM_W-1:0]   biased;
  logic signed [PROD1_W-1:0]  prod1;
  logic signed [SUM_W-1:0]    sum;
  logic        [LO_W-1:0]     lin_lo;
  logic signed [HI_W-1:0]     lin_hi;
  logic signed [WIDE_W-1:0]   wide;
  logic signed [SCL_W-1:0]    scaled;

  assign biased = BSUM_W'(bias_i) + BSUM_W'(value_i);
  assign prod1  = PROD1_W'(slope_i) * PROD1_W'(biased);

  // offset * 2^8 + slope * (bias + HU), rounded half up to Q.24.
  assign sum = SUM_W'($signed({1'b0, ofs_r, 8'b0})) + SUM_W'(prod1_r) + SUM_W'(RND_LIN);

  // The correction multiply is split into a low unsigned and a high signed part.
  assign lin_lo = lin_r[LO_W-1:0];
  assign lin_hi = lin_r[LIN_W-1:LO_W];

  assign wide   = (WIDE_W'(ph_r) <<< LO_W) + WIDE_W'(pl_r) + WIDE_W'(RND_COR);
  assign scaled = corr_en_r ? wide[WIDE_W-1:16] : SCL_W'(lin_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= ctl.start;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      done_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      prod1_r   <= prod1;
      ofs_r     <= ofs_i;
      corr_r    <= corr_i;
      corr_en_r <= ctl.corr_en;
    end
    if (v1_r) begin
      lin_r <= sum[SUM_W-1:8];
    end
    if (v2_r) begin
      pl_r <= PL_W'(lin_lo) * PL_W'(corr_r);
      ph_r <= PH_W'(lin_hi) * $signed(PH_W'(corr_r));
    end
    if (v3_r) begin
      if (scaled < SCL_W'(DENSITY_FLOOR)) begin
        density_r <= DENS_W'(DENSITY_FLOOR);
      end else if (|scaled[SCL_W-1:DENS_W]) begin
        density_r <= '1;
      end else begin
        density_r <= scaled[DENS_W-1:0];
      end
    end
  end

  assign done_o    = done_r;
  assign density_o = density_r;

endmodule

`default_nettype wire

// ----- hdl/ct_hu_to_density_material.sv -----
// A convert item passes through clamp, a scan of the section memory that reads one row
//   per cycle up to the larger of the density and material edge counts in use, a drain,
//   a fetch and the arithmetic; a new item is accepted only once the block is idle.
//   Table load items are written on their accepting edge.
// Reset (synchronous, rst_n low) sets the registers to their defaults and empties the
//   result register; the section and correction memories are not cleared.
`default_nettype none

module ct_hu_to_density_material #(
  parameter int DENSITY_EDGES    = hu2d_pkg::DENSITY_EDGES_DEF,
  parameter int MATERIAL_EDGES   = hu2d_pkg::MATERIAL_EDGES_DEF,
  parameter int CORRECTION_DEPTH = hu2d_pkg::CORRECTION_DEPTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // Input channel
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic        [hu2d_pkg::KIND_W-1:0]     in_kind,
  input  wire logic signed [hu2d_pkg::HU_W-1:0]       in_hu,
  input  wire logic        [hu2d_pkg::SLOT_W-1:0]     in_slot,
  input  wire logic signed [hu2d_pkg::HU_W-1:0]       in_edge_hu,
  input  wire logic        [hu2d_pkg::OFS_W-1:0]      in_offset_value,
  input  wire logic signed [hu2d_pkg::SLOPE_W-1:0]    in_slope,
  input  wire logic signed [hu2d_pkg::BIAS_W-1:0]     in_slope_bias,
  input  wire logic        [hu2d_pkg::CORR_W-1:0]     in_correction_value,
  // Result channel
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic             [hu2d_pkg::DENS_W-1:0]     out_density,
  output logic             [hu2d_pkg::DSEC_W-1:0]     out_density_section,
  output logic             [hu2d_pkg::MSEC_W-1:0]     out_material_section,
  // Configuration write port
  input  wire logic                                   cfg_we,
  input  wire logic        [hu2d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [hu2d_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hu2d_pkg::*;

  // The section memory holds density section i and material edge i in the same row,
  // so one read per cycle feeds both edge searches.
  localparam int SEC_DEPTH = (DENSITY_EDGES > MATERIAL_EDGES) ? DENSITY_EDGES : MATERIAL_EDGES;
  localparam int SEC_AW    = $clog2(SEC_DEPTH);
  localparam int CNT_RAW   = $clog2(SEC_DEPTH + 1);
  localparam int CNT_W     = (CNT_RAW > MSU_W + 1) ? CNT_RAW : MSU_W + 1;
  localparam int DIDX_W    = $clog2(DENSITY_EDGES);
  localparam int MIDX_W    = $clog2(MATERIAL_EDGES);
  localparam int CORR_AW   = (CORRECTION_DEPTH > 1) ? $clog2(CORRECTION_DEPTH) : 1;
  localparam int ENT_RAW   = $clog2(CORRECTION_DEPTH + 1);
  localparam int ENT_W     = (ENT_RAW > ENTRIES_W) ? ENT_RAW : ENTRIES_W;
  localparam int EXT_W     = ((ENT_W > HU_W) ? ENT_W : HU_W) + 2;
  localparam int SLOT_CMP_W = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLAMP,
    S_SCAN,
    S_DRAIN,
    S_FETCH,
    S_CALC,
    S_OUT
  } state_t;

  // Configuration registers
  logic        [DSU_W-1:0]     cfg_dsu_r;
  logic        [MSU_W-1:0]     cfg_msu_r;
  logic signed [HU_W-1:0]      cfg_base_r;
  logic        [ENTRIES_W-1:0] cfg_entries_r;

  // Memories
  sec_entry_t                  sec_mem [SEC_DEPTH];
  logic        [CORR_W-1:0]    corr_mem [CORRECTION_DEPTH];
  sec_entry_t                  sec_rd_r;
  logic        [CORR_W-1:0]    corr_rd_r;

  // Sequencer state and per-item registers
  state_t                      state_r;
  logic signed [HU_W-1:0]      hu_r;
  logic signed [HU_W-1:0]      value_r;
  logic        [ENT_W-1:0]     ent_sat_r;
  logic                        corr_en_r;
  logic        [SEC_AW-1:0]    scan_r;
  logic        [SEC_AW-1:0]    last_r;
  logic                        cmp_vld_r;
  logic        [SEC_AW-1:0]    cmp_idx_r;
  logic                        dfound_r;
  logic                        mfound_r;
  logic        [DIDX_W-1:0]    dsec_r;
  logic        [MIDX_W-1:0]    msec_r;
  logic        [DSEC_W-1:0]    dsec_out_r;
  logic        [MSEC_W-1:0]    msec_out_r;
  logic                        start_r;

  // Result register
  logic                        out_valid_r;
  logic        [DENS_W-1:0]    out_density_r;
  logic        [DSEC_W-1:0]    out_dsec_r;
  logic        [MSEC_W-1:0]    out_msec_r;

  // Combinational helpers
  logic                        in_fire;
  logic                        dens_we, corr_we, mat_we;
  logic                        out_free;
  logic        [CNT_W-1:0]     dsu_cnt, msu_cnt, dcount, mcount, cnt_max;
  logic        [SEC_AW-1:0]    lastc;
  logic        [ENT_W-1:0]     ent_sat;
  logic signed [HU_W-1:0]      val_lo, val_clamped;
  logic signed [EXT_W-1:0]     val_lo_x, hu_max_x;
  logic signed [EXT_W-1:0]     cdiff, clim, cidx;
  logic        [DIDX_W-1:0]    dsec_fin;
  logic        [MIDX_W-1:0]    msec_fin;
  logic                        sec_re, corr_re;
  logic        [SEC_AW-1:0]    sec_raddr;
  logic        [CORR_AW-1:0]   corr_raddr;
  calc_ctl_t                   calc_ctl;
  logic                        calc_done;
  logic        [DENS_W-1:0]    calc_density;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // ---------------------------------------------------------------------------
  // Config registers: writes must arrive only while no item is in flight (not enforced).
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_dsu_r     <= DSU_W'(DSU_RESET);
      cfg_msu_r     <= MSU_W'(MSU_RESET);
      cfg_base_r    <= HU_W'(BASE_RESET);
      cfg_entries_r <= ENTRIES_W'(ENTRIES_RESET);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DENSITY_SECTIONS:   cfg_dsu_r     <= cfg_wdata[DSU_W-1:0];
        CFG_MATERIAL_SECTIONS:  cfg_msu_r     <= cfg_wdata[MSU_W-1:0];
        CFG_CORRECTION_BASE:    cfg_base_r    <= cfg_wdata[HU_W-1:0];
        CFG_CORRECTION_ENTRIES: cfg_entries_r <= cfg_wdata[ENTRIES_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Table loads. A load transfer writes its memory on the accepting edge; slots
  // beyond a table's depth are dropped. Since one item is handled at a time, a
  // load never overlaps the reads of a conversion.
  // ---------------------------------------------------------------------------
  assign dens_we = in_fire && (kind_t'(in_kind) == KIND_DENSITY) &&
                   (SLOT_CMP_W'(in_slot) < SLOT_CMP_W'(DENSITY_EDGES));
  assign corr_we = in_fire && (kind_t'(in_kind) == KIND_CORRECTION) &&
                   (SLOT_CMP_W'(in_slot) < SLOT_CMP_W'(CORRECTION_DEPTH));
  assign mat_we  = in_fire && (kind_t'(in_kind) == KIND_MATERIAL) &&
                   (SLOT_CMP_W'(in_slot) < SLOT_CMP_W'(MATERIAL_EDGES));

  always_ff @(posedge clk) begin
    if (dens_we) begin
      sec_mem[SEC_AW'(in_slot)].dedge <= in_edge_hu;
      sec_mem[SEC_AW'(in_slot)].ofs   <= in_offset_value;
      sec_mem[SEC_AW'(in_slot)].slope <= in_slope;
      sec_mem[SEC_AW'(in_slot)].bias  <= in_slope_bias;
    end
    if (mat_we) begin
      sec_mem[SEC_AW'(in_slot)].medge <= in_edge_hu;
    end
    if (sec_re) begin
      sec_rd_r <= sec_mem[sec_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (corr_we) begin
      corr_mem[CORR_AW'(in_slot)] <= in_correction_value;
    end
    if (corr_re) begin
      corr_rd_r <= corr_mem[corr_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Edge counts in use, each limited to its store's depth, and the length of
  // the scan that covers both searches.
  // ---------------------------------------------------------------------------
  assign dsu_cnt = CNT_W'(cfg_dsu_r) + CNT_W'(1);
  assign msu_cnt = CNT_W'(cfg_msu_r) + CNT_W'(1);
  assign dcount  = (dsu_cnt > CNT_W'(DENSITY_EDGES))  ? CNT_W'(DENSITY_EDGES)  : dsu_cnt;
  assign mcount  = (msu_cnt > CNT_W'(MATERIAL_EDGES)) ? CNT_W'(MATERIAL_EDGES) : msu_cnt;
  assign cnt_max = (dcount > mcount) ? dcount : mcount;
  assign lastc   = SEC_AW'(cnt_max - CNT_W'(1));

  // ---------------------------------------------------------------------------
  // HU clamp to the correction span. The lower bound always applies; the upper
  // bound only when two or more correction entries are in use.
  // ---------------------------------------------------------------------------
  assign ent_sat  = (ENT_W'(cfg_entries_r) > ENT_W'(CORRECTION_DEPTH)) ?
                    ENT_W'(CORRECTION_DEPTH) : ENT_W'(cfg_entries_r);
  assign val_lo   = (hu_r < cfg_base_r) ? cfg_base_r : hu_r;
  assign val_lo_x = EXT_W'(val_lo);
  assign hu_max_x = EXT_W'(cfg_base_r) + $signed(EXT_W'(ent_sat)) - EXT_W'(1);
  assign val_clamped = ((ent_sat >= ENT_W'(2)) && (val_lo_x > hu_max_x)) ?
                       hu_max_x[HU_W-1:0] : val_lo;

  // Correction entry of the clamped HU. With a single entry every HU maps to it.
  assign cdiff = EXT_W'(value_r) - EXT_W'(cfg_base_r);
  assign clim  = $signed(EXT_W'(ent_sat_r)) - EXT_W'(1);
  assign cidx  = (cdiff > clim) ? clim : cdiff;

  // When no edge beyond the first was above the HU, the last section is taken;
  // with a single edge in use the section is zero.
  assign dsec_fin = dfound_r ? dsec_r :
                    (dcount < CNT_W'(2)) ? '0 : DIDX_W'(dcount - CNT_W'(2));
  assign msec_fin = mfound_r ? msec_r :
                    (mcount < CNT_W'(2)) ? '0 : MIDX_W'(mcount - CNT_W'(2));

  // Memory read ports: edge i during the scan, then the chosen section's
  // coefficients together with the correction entry.
  always_comb begin
    sec_re     = 1'b0;
    sec_raddr  = scan_r;
    corr_re    = 1'b0;
    corr_raddr = cidx[CORR_AW-1:0];
    unique case (state_r)
      S_SCAN: begin
        sec_re = 1'b1;
      end
      S_FETCH: begin
        sec_re    = 1'b1;
        sec_raddr = SEC_AW'(dsec_fin);
        corr_re   = corr_en_r;
      end
      default: begin
        sec_re = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer. A convert transfer moves through clamp, an edge scan that reads
  // one memory row per cycle, a drain state for the last compare, a fetch of the
  // section coefficients, then the four-stage arithmetic. The result register
  // lets the next item be accepted while the previous result still waits.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      start_r     <= 1'b0;
      dfound_r    <= 1'b0;
      mfound_r    <= 1'b0;
      scan_r      <= '0;
      last_r      <= '0;
    end else begin
      cmp_vld_r <= (state_r == S_SCAN);
      cmp_idx_r <= scan_r;
      start_r   <= (state_r == S_FETCH);

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      // Edge compare on the row read in the previous cycle. The first edge whose
      // value lies above the HU ends each search; section = edge index - 1.
      if (cmp_vld_r) begin
        if (!dfound_r && (CNT_W'(cmp_idx_r) < dcount) && (value_r < sec_rd_r.dedge)) begin
          dfound_r <= 1'b1;
          dsec_r   <= DIDX_W'(cmp_idx_r - SEC_AW'(1));
        end
        if (!mfound_r && (CNT_W'(cmp_idx_r) < mcount) && (hu_r < sec_rd_r.medge)) begin
          mfound_r <= 1'b1;
          msec_r   <= MIDX_W'(cmp_idx_r - SEC_AW'(1));
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire && (kind_t'(in_kind) == KIND_CONVERT)) begin
            hu_r    <= in_hu;
            state_r <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          value_r   <= val_clamped;
          ent_sat_r <= ent_sat;
          corr_en_r <= (ent_sat != '0);
          dfound_r  <= 1'b0;
          mfound_r  <= 1'b0;
          scan_r    <= SEC_AW'(1);
          last_r    <= lastc;
          state_r   <= (lastc == '0) ? S_DRAIN : S_SCAN;
        end
        S_SCAN: begin
          scan_r <= scan_r + SEC_AW'(1);
          if (scan_r == last_r) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_FETCH;
        end
        S_FETCH: begin
          dsec_out_r <= DSEC_W'(dsec_fin);
          msec_out_r <= MSEC_W'(msec_fin);
          state_r    <= S_CALC;
        end
        S_CALC: begin
          if (calc_done) begin
            if (out_free) begin
              out_valid_r   <= 1'b1;
              out_density_r <= calc_density;
              out_dsec_r    <= dsec_out_r;
              out_msec_r    <= msec_out_r;
              state_r       <= S_IDLE;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_density_r <= calc_density;
            out_dsec_r    <= dsec_out_r;
            out_msec_r    <= msec_out_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Density arithmetic on the fetched section and correction entry.
  // ---------------------------------------------------------------------------
  assign calc_ctl.start   = start_r;
  assign calc_ctl.corr_en = corr_en_r;

  hu2d_calc u_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (calc_ctl),
    .ofs_i     (sec_rd_r.ofs),
    .slope_i   (sec_rd_r.slope),
    .bias_i    (sec_rd_r.bias),
    .value_i   (value_r),
    .corr_i    (corr_rd_r),
    .done_o    (calc_done),
    .density_o (calc_density)
  );

  assign out_valid            = out_valid_r;
  assign out_density          = out_density_r;
  assign out_density_section  = out_dsec_r;
  assign out_material_section = out_msec_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_floor_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_density_r >= DENS_W'(DENSITY_FLOOR)))
    else $error("result density below the floor");

  a_load_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_kind != KIND_CONVERT)) |=> (state_r == S_IDLE))
    else $error("load transfer started a conversion");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ((scan_r <= last_r) && (scan_r != '0)))
    else $error("edge scan left its range");

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    calc_done |-> (state_r == S_CALC))
    else $error("arithmetic finished outside the wait state");

endmodule

`default_nettype wire

// ----- verif/hu2d_voxel_checker.sv -----
// Checker for the HU to density and material converter: it watches the input,
// result and register write ports, predicts every conversion and compares it.
// Depends on hu2d_pkg for field widths, item kinds and register codes.
`timescale 1ns / 100ps

module hu2d_voxel_checker (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  input  wire logic                                   in_ready,
  input  wire logic        [hu2d_pkg::KIND_W-1:0]     in_kind,
  input  wire logic signed [hu2d_pkg::HU_W-1:0]       in_hu,
  input  wire logic        [hu2d_pkg::SLOT_W-1:0]     in_slot,
  input  wire logic signed [hu2d_pkg::HU_W-1:0]       in_edge_hu,
  input  wire logic        [hu2d_pkg::OFS_W-1:0]      in_offset_value,
  input  wire logic signed [hu2d_pkg::SLOPE_W-1:0]    in_slope,
  input  wire logic signed [hu2d_pkg::BIAS_W-1:0]     in_slope_bias,
  input  wire logic        [hu2d_pkg::CORR_W-1:0]     in_correction_value,
  input  wire logic                                   out_valid,
  input  wire logic                                   out_ready,
  input  wire logic        [hu2d_pkg::DENS_W-1:0]     out_density,
  input  wire logic        [hu2d_pkg::DSEC_W-1:0]     out_density_section,
  input  wire logic        [hu2d_pkg::MSEC_W-1:0]     out_material_section,
  input  wire logic                                   cfg_we,
  input  wire logic        [hu2d_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [hu2d_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                                          error_count,
  output int                                          voxels_pending,
  output int                                          voxels_checked
);
  import hu2d_pkg::*;

  localparam longint DENSITY_MAX = 64'h0000_0000_FFFF_FFFF;

  typedef struct {
    logic [DENS_W-1:0] density;
    logic [DSEC_W-1:0] dsec;
    logic [MSEC_W-1:0] msec;
  } voxel_t;

  // Shadow copies of the tables and registers.
  int             dedge_tab [DENSITY_EDGES_DEF];
  logic [OFS_W-1:0] ofs_tab [DENSITY_EDGES_DEF];
  int             slope_tab [DENSITY_EDGES_DEF];
  int             bias_tab  [DENSITY_EDGES_DEF];
  int             medge_tab [MATERIAL_EDGES_DEF];
  int             corr_tab  [CORRECTION_DEPTH_DEF];
  int             dsu_cfg;
  int             msu_cfg;
  int             base_cfg;
  int             entries_cfg;

  voxel_t expected_voxels [$];

  // First section whose upper edge lies above the HU; the lowest edge is never compared.
  function automatic int section_of(input bit material, input int count, input int hu_val);
    int i;
    int edge_hu;
    if (count < 2) return 0;
    for (i = 0; i + 1 < count; i++) begin
      edge_hu = material ? medge_tab[i+1] : dedge_tab[i+1];
      if (hu_val < edge_hu) return i;
    end
    return count - 2;
  endfunction

  function automatic voxel_t convert_hu(input int hu_val);
    voxel_t v;
    int     entries;
    int     dcount;
    int     mcount;
    int     clamped;
    int     dsec;
    int     msec;
    longint idx;
    longint q32;
    longint lin;
    longint dens;
    entries = (entries_cfg > CORRECTION_DEPTH_DEF) ? CORRECTION_DEPTH_DEF : entries_cfg;
    dcount  = (dsu_cfg + 1 > DENSITY_EDGES_DEF) ? DENSITY_EDGES_DEF : dsu_cfg + 1;
    mcount  = (msu_cfg + 1 > MATERIAL_EDGES_DEF) ? MATERIAL_EDGES_DEF : msu_cfg + 1;
    clamped = (hu_val < base_cfg) ? base_cfg : hu_val;
    if (entries >= 2 && clamped > base_cfg + entries - 1) clamped = base_cfg + entries - 1;
    dsec = section_of(1'b0, dcount, clamped);
    // Linear term exact in Q.32, then rounded half up to Q.24.
    q32  = (longint'(ofs_tab[dsec]) <<< 8)
         + longint'(slope_tab[dsec]) * longint'(bias_tab[dsec] + clamped);
    lin  = (q32 + 128) >>> 8;
    dens = lin;
    if (entries > 0) begin
      idx = longint'(clamped) - longint'(base_cfg);
      if (idx < 0) idx = 0;
      if (idx > entries - 1) idx = entries - 1;
      dens = (lin * longint'(corr_tab[int'(idx)]) + 32768) >>> 16;
    end
    if (dens < DENSITY_FLOOR) dens = DENSITY_FLOOR;
    if (dens > DENSITY_MAX) dens = DENSITY_MAX;
    msec = section_of(1'b1, mcount, hu_val);
    if (msec > 255) msec = 255;
    v.density = dens[DENS_W-1:0];
    v.dsec    = dsec[DSEC_W-1:0];
    v.msec    = msec[MSEC_W-1:0];
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: voxel %0d: %s", $time, voxels_checked, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    voxel_t want;
    if (!rst_n) begin
      dsu_cfg     = DSU_RESET;
      msu_cfg     = MSU_RESET;
      base_cfg    = BASE_RESET;
      entries_cfg = ENTRIES_RESET;
      expected_voxels.delete();
      voxels_pending <= 0;
    end else begin
      // Results are checked before new items are queued; no item returns in its own cycle.
      if (out_valid && out_ready) begin
        if (expected_voxels.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing expected, density %0h",
                                    out_density));
        end else begin
          want = expected_voxels.pop_front();
          if (out_density !== want.density)
            report_mismatch($sformatf("density got %0h expected %0h",
                                      out_density, want.density));
          if (out_density_section !== want.dsec)
            report_mismatch($sformatf("density section got %0d expected %0d",
                                      out_density_section, want.dsec));
          if (out_material_section !== want.msec)
            report_mismatch($sformatf("material section got %0d expected %0d",
                                      out_material_section, want.msec));
          voxels_checked++;
        end
      end
      if (in_valid && in_ready) begin
        case (kind_t'(in_kind))
          KIND_CONVERT: begin
            expected_voxels.insert(expected_voxels.size(), convert_hu(int'(in_hu)));
          end
          KIND_DENSITY: begin
            if (in_slot < DENSITY_EDGES_DEF) begin
              dedge_tab[in_slot] = int'(in_edge_hu);
              ofs_tab[in_slot]   = in_offset_value;
              slope_tab[in_slot] = int'(in_slope);
              bias_tab[in_slot]  = int'(in_slope_bias);
            end
          end
          KIND_CORRECTION: begin
            if (in_slot < CORRECTION_DEPTH_DEF) corr_tab[in_slot] = int'(in_correction_value);
          end
          KIND_MATERIAL: begin
            if (in_slot < MATERIAL_EDGES_DEF) medge_tab[in_slot] = int'(in_edge_hu);
          end
          default: ;
        endcase
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_DENSITY_SECTIONS:   dsu_cfg     = int'(cfg_wdata[DSU_W-1:0]);
          CFG_MATERIAL_SECTIONS:  msu_cfg     = int'(cfg_wdata[MSU_W-1:0]);
          CFG_CORRECTION_BASE:    base_cfg    = int'($signed(cfg_wdata));
          CFG_CORRECTION_ENTRIES: entries_cfg = int'(cfg_wdata[ENTRIES_W-1:0]);
          default: ;
        endcase
      end
      voxels_pending <= expected_voxels.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
// Top of the converter testbench: clock, reset, stimulus, output stall pattern
// and verdict. Instantiates ct_hu_to_density_material and hu2d_voxel_checker.
// Depends on hu2d_pkg for kinds, register codes and field widths.
`timescale 1ns / 100ps

module testbench;
  import hu2d_pkg::*;

  // Worst case convert latency with every edge of both tables in use, plus margin.
  localparam int LATENCY_MAX    = 40;
  localparam int SETTLE         = LATENCY_MAX + 10;
  localparam int LONG_HOLD      = 500;
  // Longest correct stretch without a transfer is the long hold plus one latency;
  // the watchdog allows several times that.
  localparam int WATCHDOG_LIMIT = 4000;
  // Correction entries written up front; register settings keep every reachable
  // entry below this count.
  localparam int CORR_FILL      = 256;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic        [KIND_W-1:0]    in_kind;
  logic signed [HU_W-1:0]      in_hu;
  logic        [SLOT_W-1:0]    in_slot;
  logic signed [HU_W-1:0]      in_edge_hu;
  logic        [OFS_W-1:0]     in_offset_value;
  logic signed [SLOPE_W-1:0]   in_slope;
  logic signed [BIAS_W-1:0]    in_slope_bias;
  logic        [CORR_W-1:0]    in_correction_value;
  logic                        out_valid;
  logic                        out_ready;
  logic        [DENS_W-1:0]    out_density;
  logic        [DSEC_W-1:0]    out_density_section;
  logic        [MSEC_W-1:0]    out_material_section;
  logic                        cfg_we;
  logic        [CFG_IDX_W-1:0] cfg_index;
  logic        [CFG_DATA_W-1:0] cfg_wdata;

  int error_count;
  int voxels_pending;
  int voxels_checked;

  // Stimulus bookkeeping. cur_base and cur_entries steer HU values toward the clamp range.
  bit no_idle;
  bit hold_long;
  int cur_base;
  int cur_entries;
  int n_converts;
  int n_loads;
  int n_settings;
  int idle_cycles;

  ct_hu_to_density_material u_top (.*);

  hu2d_voxel_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Gap length shared by sender and receiver: mostly none or short, now and then long.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Offers one item and returns at the edge where its transfer happens. Valid is only
  // lowered when a gap precedes the next item, so it never toggles within one step.
  task automatic offer(input kind_t kind, input int hu, input int slot, input int edge_val,
                       input logic [31:0] ofs, input logic [31:0] slope, input int bias,
                       input int corr);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_kind             <= kind;
    in_hu               <= hu[HU_W-1:0];
    in_slot             <= slot[SLOT_W-1:0];
    in_edge_hu          <= edge_val[HU_W-1:0];
    in_offset_value     <= ofs;
    in_slope            <= slope;
    in_slope_bias       <= bias[BIAS_W-1:0];
    in_correction_value <= corr[CORR_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == KIND_CONVERT) n_converts++;
    else n_loads++;
  endtask

  // Fields that a kind does not use carry random noise.
  task automatic convert(input int hu);
    offer(KIND_CONVERT, hu, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic load_density(input int slot, input int edge_val, input logic [31:0] ofs,
                              input logic [31:0] slope, input int bias);
    offer(KIND_DENSITY, $urandom, slot, edge_val, ofs, slope, bias, $urandom);
  endtask

  task automatic load_correction(input int slot, input int value);
    offer(KIND_CORRECTION, $urandom, slot, $urandom, $urandom, $urandom, $urandom, value);
  endtask

  task automatic load_material(input int slot, input int edge_val);
    offer(KIND_MATERIAL, $urandom, slot, edge_val, $urandom, $urandom, $urandom, $urandom);
  endtask

  // Section contents: mostly tissue-like densities and slopes, sometimes anything at all,
  // which drives the result into the floor and into saturation.
  function automatic logic [31:0] pick_offset();
    if ($urandom_range(0, 3) != 0) return $urandom_range(32'h0040_0000, 32'h0300_0000);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_slope();
    if ($urandom_range(0, 3) != 0) return $urandom_range(0, 12_000_000) - 32'd4_000_000;
    return $urandom;
  endfunction

  function automatic int pick_bias();
    if ($urandom_range(0, 3) != 0) return int'($urandom_range(0, 2000)) - 1000;
    return $urandom;
  endfunction

  function automatic int pick_edge();
    if ($urandom_range(0, 9) < 7) return int'($urandom_range(0, 4400)) - 1200;
    return $urandom;
  endfunction

  function automatic int pick_correction();
    if ($urandom_range(0, 9) < 7) return $urandom_range(57344, 73728);
    return $urandom_range(0, 262143);
  endfunction

  // Mostly a valid slot of the table, sometimes any slot, which the block must ignore.
  function automatic int pick_slot(input int depth);
    if ($urandom_range(0, 9) != 0) return $urandom_range(0, depth - 1);
    return $urandom_range(0, 4095);
  endfunction

  function automatic int pick_hu();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return $urandom;
    if (r < 60) return int'($urandom_range(0, 4400)) - 1200;
    if (r < 85) return cur_base - 3 + int'($urandom_range(0, cur_entries + 5));
    case ($urandom_range(0, 3))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  // Well-formed tables: ascending edges, either around the tissue range or across the
  // whole HU span.
  task automatic density_ramp(input bit wide);
    int slot;
    int e;
    e = wide ? -32768 : int'($urandom_range(0, 200)) - 1100;
    for (slot = 0; slot < DENSITY_EDGES_DEF; slot++) begin
      load_density(slot, e, pick_offset(), pick_slope(), pick_bias());
      e += wide ? int'($urandom_range(1, 4000)) : int'($urandom_range(10, 300));
    end
  endtask

  task automatic material_ramp(input bit wide);
    int slot;
    int e;
    e = wide ? -32768 : int'($urandom_range(0, 200)) - 1100;
    for (slot = 0; slot < MATERIAL_EDGES_DEF; slot++) begin
      load_material(slot, e);
      e += wide ? int'($urandom_range(1, 2000)) : int'($urandom_range(5, 150));
    end
  endtask

  task automatic fill_correction(input int first, input int count);
    int slot;
    for (slot = first; slot < first + count; slot++) load_correction(slot, pick_correction());
  endtask

  // Waits until every expected result has arrived, then lets a table load that was
  // the last item settle inside the block before registers change.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (voxels_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_regs(input int dsu, input int msu, input int base, input int entries);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DENSITY_SECTIONS;
    cfg_wdata <= dsu[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_MATERIAL_SECTIONS;
    cfg_wdata <= msu[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_CORRECTION_BASE;
    cfg_wdata <= base[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_CORRECTION_ENTRIES;
    cfg_wdata <= entries[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we      <= 1'b0;
    cur_base    = base;
    cur_entries = entries;
    n_settings++;
  endtask

  // Random traffic: mostly conversions, with single table writes that may break the edge
  // order and now and then a whole well-formed reload that restores it. With squeeze set,
  // the receiver holds off for a long stretch a third of the way in while items keep coming.
  task automatic random_traffic(input int n, input bit squeeze);
    int i;
    int r;
    for (i = 0; i < n; i++) begin
      if (squeeze && i == n / 3) hold_long = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 62) convert(pick_hu());
      else if (r < 74) load_density(pick_slot(DENSITY_EDGES_DEF), pick_edge(), pick_offset(),
                                    pick_slope(), pick_bias());
      else if (r < 86) load_correction($urandom_range(0, 4095), pick_correction());
      else if (r < 97) load_material(pick_slot(MATERIAL_EDGES_DEF), pick_edge());
      else if (r < 99) density_ramp(1'($urandom_range(0, 1)));
      else material_ramp(1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(input int dsu, input int msu, input int base, input int entries,
                           input bit squeeze);
    drain();
    write_regs(dsu, msu, base, entries);
    random_traffic(50, squeeze);
  endtask

  // Receiver: stretches of ready with random stalls in between, plus one long hold
  // on request that lets the block fill up and stall its input.
  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        n = idle_gap();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Watchdog: a long run of cycles without any transfer means the block is hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, voxels_pending);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n               <= 1'b0;
    in_valid            <= 1'b0;
    in_kind             <= KIND_CONVERT;
    in_hu               <= '0;
    in_slot             <= '0;
    in_edge_hu          <= '0;
    in_offset_value     <= '0;
    in_slope            <= '0;
    in_slope_bias       <= '0;
    in_correction_value <= '0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_DENSITY_SECTIONS;
    cfg_wdata           <= '0;
    no_idle     = 1'b0;
    hold_long   = 1'b0;
    cur_base    = BASE_RESET;
    cur_entries = ENTRIES_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // The tables come out of reset undefined, so every entry that a conversion can read
    // is written before the first one: all section rows and the correction entries below
    // CORR_FILL. Registers keep their reset values for this phase.
    density_ramp(1'b0);
    material_ramp(1'b0);
    fill_correction(0, CORR_FILL);

    // Directed items. Writes past the end of a table must be dropped.
    load_density(DENSITY_EDGES_DEF, pick_edge(), $urandom, $urandom, $urandom);
    load_density(4095, pick_edge(), $urandom, $urandom, $urandom);
    load_material(MATERIAL_EDGES_DEF, pick_edge());
    load_material(4095, pick_edge());
    // HU extremes and the lower clamp boundary.
    convert(-32768);
    convert(32767);
    convert(-1000);
    convert(-1001);
    convert(0);
    convert(-1);
    // HU exactly on a material edge and on a density edge.
    load_material(1, 0);
    convert(0);
    convert(-1);
    load_density(1, -999, pick_offset(), pick_slope(), pick_bias());
    convert(-999);
    // Lowest section: a huge positive product saturates, a negative one hits the floor,
    // and the largest offset with zero slope lands exactly on full scale.
    load_density(0, -32768, 32'h0, 32'h8000_0000, 0);
    convert(-1000);
    load_density(0, -32768, 32'h0, 32'h7FFF_FFFF, -32768);
    convert(-1000);
    load_density(0, -32768, 32'hFFFF_FFFF, 32'h0, 0);
    convert(-1000);
    random_traffic(60, 1'b0);

    // Register settings, extremes of every field among them. The full correction count
    // is used with the base at the top of the HU range, where every HU reads entry zero.
    run_phase(15, 31, -1024, CORR_FILL, 1'b0);
    run_phase(1, 1, -32768, CORR_FILL, 1'b0);
    run_phase(15, 31, 32767, 1, 1'b1);
    no_idle = 1'b1;
    run_phase(1, 31, 0, 2, 1'b0);
    no_idle = 1'b0;
    run_phase($urandom_range(1, 15), $urandom_range(1, 31), int'($urandom_range(0, 200)) - 1100,
              $urandom_range(0, CORR_FILL), 1'b0);
    run_phase(15, 1, 32767, CORRECTION_DEPTH_DEF, 1'b0);
    run_phase($urandom_range(1, 15), $urandom_range(1, 31),
              int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, CORR_FILL), 1'b1);
    drain();

    $display("Converted %0d HU values (%0d results checked) around %0d table loads,",
             n_converts, voxels_checked, n_loads);
    $display("across %0d register settings, with long output stalls and a gap-free phase.",
             n_settings + 1);
    if (error_count == 0 && voxels_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- ct_hu_to_density_material.f -----
hdl/hu2d_pkg.sv
hdl/hu2d_calc.sv
hdl/ct_hu_to_density_material.sv
verif/hu2d_voxel_checker.sv
verif/testbench.sv
